[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MDRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MDRE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MDRE_ASSERT(lbl, clk, rstn, prop, msg)
`define MDRE_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[design/mdre_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mdre_pkg;

  localparam int MEM_WORDS_DEF = 16384;
  localparam int GAP_STEP_DEF  = 32768;
  localparam int MAX_RES       = 6;
  localparam int CNT_W         = 3;
  localparam int CFG_W         = 15;

  localparam logic [15:0] NO_WRITE = 16'hFFFF;
  localparam logic [15:0] LEN_SAT  = 16'hFFFF;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OFFS = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic                      load;
    logic [CNT_W-1:0]          cnt;
    entry_t [MAX_RES-1:0]      ent;
  } burst_t;

endpackage

`default_nettype wire

[design/mdre_ref_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module mdre_ref_mem import mdre_pkg::*; #(
  parameter int DEPTH = MEM_WORDS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [15:0]   rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-entry collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/mdre_run.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mdre_run import mdre_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int GAP_STEP  = GAP_STEP_DEF,
  parameter int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1,
  parameter int LEN_W     = $clog2(MEM_WORDS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [AW-1:0] acc_pos,
  input  wire logic          acc_end,
  input  wire logic [15:0]   acc_word,
  input  wire logic [15:0]   rd_data,
  input  wire logic          burst_free,
  output      logic          busy,
  output      logic          wr_en,
  output      logic [AW-1:0] wr_addr,
  output      logic [15:0]   wr_data,
  output      burst_t        burst
);

  localparam logic [15:0] GAP = 16'(GAP_STEP);

  logic             s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]    s1_pos_r;
  logic             s1_end_r;
  logic [15:0]      s1_word_r;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             in_run_r, in_run_nxt;
  logic [15:0]      start_r, start_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      last_wr_r, last_wr_nxt;

  logic             go, fresh, differ, inrun_u, close, gap;
  logic [15:0]      ref_val, start_u, len_u, rel, rel_out;
  entry_t           cand [MAX_RES];
  logic [MAX_RES-1:0] cand_v;
  entry_t [MAX_RES-1:0] list;
  logic [CNT_W-1:0] n;

  assign go   = s1_valid_r && burst_free;
  assign busy = s1_valid_r && !burst_free;
  assign s1_valid_nxt = acc || busy;

  always_comb begin
    fresh   = (17'(s1_pos_r) == 17'(fill_r));
    ref_val = fresh ? 16'h0000 : rd_data;
    differ  = (s1_word_r != ref_val);
    inrun_u = in_run_r || differ;
    start_u = start_r;
    len_u   = len_r;
    if (differ) begin
      if (!in_run_r) begin
        start_u = 16'(s1_pos_r);
        len_u   = 16'd1;
      end else if (len_r != LEN_SAT) begin
        len_u = len_r + 16'd1;
      end
    end
    close   = (!differ && in_run_r) || (s1_end_r && inrun_u);
    rel     = (last_wr_r == NO_WRITE) ? start_u : start_u - last_wr_r;
    gap     = (rel >= GAP);
    rel_out = gap ? rel - GAP : rel;

    cand[0] = '{kind: KIND_DATA, value: s1_word_r, last: 1'b0};
    cand[1] = '{kind: KIND_OFFS, value: GAP,       last: 1'b0};
    cand[2] = '{kind: KIND_OFFS, value: 16'h0000,  last: 1'b0};
    cand[3] = '{kind: KIND_OFFS, value: rel_out,   last: 1'b0};
    cand[4] = '{kind: KIND_RUN,  value: len_u,     last: 1'b0};
    cand[5] = '{kind: KIND_DONE, value: 16'h0000,  last: 1'b1};
    cand_v  = {s1_end_r, close, close, close && gap, close && gap, differ};

    list = '0;
    n    = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (cand_v[i]) begin
        list[n] = cand[i];
        n = n + CNT_W'(1);
      end
    end
  end

  always_comb begin
    in_run_nxt  = in_run_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    last_wr_nxt = last_wr_r;
    fill_nxt    = fill_r;
    if (go) begin
      if (fresh) begin
        fill_nxt = fill_r + LEN_W'(1);
      end
      if (s1_end_r) begin
        in_run_nxt  = 1'b0;
        start_nxt   = '0;
        len_nxt     = '0;
        last_wr_nxt = NO_WRITE;
      end else if (close) begin
        in_run_nxt  = 1'b0;
        start_nxt   = '0;
        len_nxt     = '0;
        last_wr_nxt = start_u + len_u - 16'd1;
      end else begin
        in_run_nxt  = inrun_u;
        start_nxt   = start_u;
        len_nxt     = len_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fill_r     <= '0;
      in_run_r   <= 1'b0;
      start_r    <= '0;
      len_r      <= '0;
      last_wr_r  <= NO_WRITE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      fill_r     <= fill_nxt;
      in_run_r   <= in_run_nxt;
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      last_wr_r  <= last_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pos_r  <= acc_pos;
      s1_end_r  <= acc_end;
      s1_word_r <= acc_word;
    end
  end

  assign wr_en   = go && (differ || fresh);
  assign wr_addr = s1_pos_r;
  assign wr_data = s1_word_r;

  assign burst.load = go;
  assign burst.cnt  = n;
  assign burst.ent  = list;

  `MDRE_NEVER(a_fill_range, clk, rst_n, 17'(fill_r) > 17'(MEM_WORDS), "fill count past depth")
  `MDRE_NEVER(a_pos_filled, clk, rst_n, s1_valid_r && (17'(s1_pos_r) > 17'(fill_r)),
              "word read beyond fill count")
  `MDRE_NEVER(a_acc_busy, clk, rst_n, acc && busy, "word taken while stage busy")

endmodule

`default_nettype wire

[design/mdre_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mdre_emit import mdre_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire burst_t      burst,
  output      logic        burst_free,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_kind,
  output      logic [15:0] out_value,
  output      logic        out_last
);

  entry_t           buf_r [MAX_RES];
  entry_t           buf_nxt [MAX_RES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             take;

  assign out_valid  = (cnt_r != '0);
  assign take       = out_valid && !out_stall;
  assign burst_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && take);

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    cnt_nxt = cnt_r;
    if (burst.load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_nxt[i] = burst.ent[i];
      end
      cnt_nxt = burst.cnt;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  assign out_kind  = buf_r[0].kind;
  assign out_value = buf_r[0].value;
  assign out_last  = buf_r[0].last;

  `MDRE_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(MAX_RES), "burst count out of range")
  `MDRE_NEVER(a_load_busy, clk, rst_n, burst.load && !burst_free, "burst loaded over pending words")
  `MDRE_ASSERT(a_last_done, clk, rst_n, (out_valid && out_last) |-> (out_kind == KIND_DONE),
               "last flag on a non-done word")

endmodule

`default_nettype wire

[design/memory_delta_run_encoder_top.sv]
// memory delta run encoder
// in_ channel: one current memory word per accepted word, in index order.
// out_ channel: kind/value/last result words (data, offset or gap marker,
//   run count, scan done with last set).
// cfg_we with cfg_scan_words sets the scan length (0 acts as 1, values above
//   the memory depth act as the depth); write only while the block is idle.
// the compare stage registers each accepted item; it is loaded into the output
//   buffer once that is free, and its first result shows on out_ from there.
// throughput: one input word per cycle while each item yields at most one
//   result word and out_stall is low; an item's words (up to six, when a
//   run closes at the scan end) leave a six-entry output buffer one per
//   cycle unless stalled, and the next item moves on as the last is taken.
// the reference copy sits in a single-port-write, one-read memory read in the
//   accept cycle; entries at or above a fill count read as zero, so no
//   clearing pass is needed after reset.
// reset: run state, scan position and fill count clear, scan length returns
//   to the memory depth, the output buffer empties.
// out_stall holds the presented word; the input stalls while a finished item
//   waits for the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module memory_delta_run_encoder_top import mdre_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int GAP_STEP  = GAP_STEP_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_scan_words,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [15:0]      in_current_word,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [1:0]       out_kind,
  output      logic [15:0]      out_value,
  output      logic             out_last
);

  localparam int AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int LEN_W = $clog2(MEM_WORDS + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             acc, scan_end, busy, burst_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [15:0]      wr_data, rd_data;
  burst_t           burst;

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  assign scan_end = (17'(pos_r) + 17'd1) >= 17'(len_r);

  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (cfg_scan_words == '0) begin
        len_nxt = LEN_W'(1);
      end else if (17'(cfg_scan_words) > 17'(MEM_WORDS)) begin
        len_nxt = LEN_W'(MEM_WORDS);
      end else begin
        len_nxt = LEN_W'(cfg_scan_words);
      end
    end
    pos_nxt = pos_r;
    if (acc) begin
      pos_nxt = scan_end ? '0 : pos_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(MEM_WORDS);
      pos_r <= '0;
    end else begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
    end
  end

  mdre_ref_mem #(
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (pos_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mdre_run #(
    .MEM_WORDS (MEM_WORDS),
    .GAP_STEP  (GAP_STEP),
    .AW        (AW),
    .LEN_W     (LEN_W)
  ) u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_pos    (pos_r),
    .acc_end    (scan_end),
    .acc_word   (in_current_word),
    .rd_data    (rd_data),
    .burst_free (burst_free),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .burst      (burst)
  );

  mdre_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .burst_free (burst_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

[tb/sv/memory_delta_run_encoder_checker.sv]
`timescale 1ns / 1ps

module memory_delta_run_encoder_checker import mdre_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int GAP_STEP  = GAP_STEP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_scan_words,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [15:0]      in_current_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_kind,
  input  logic [15:0]      out_value,
  input  logic             out_last,
  output int unsigned      pending,
  output int unsigned      errors
);

  localparam logic [15:0] GAP_VAL = 16'(GAP_STEP);

  logic [15:0]      shadow_mem [MEM_WORDS];
  logic [15:0]      scan_pos;
  logic [15:0]      run_first;
  logic [15:0]      run_len;
  logic [15:0]      last_wr_idx;
  logic             in_run;
  logic [CFG_W-1:0] scan_len_cfg;
  entry_t           expected_words [$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
    errors++;
  endtask

  // newest at the front, oldest at the back
  task automatic expect_word(input logic [1:0] k, input logic [15:0] v, input logic l);
    entry_t e;
    e.kind  = k;
    e.value = v;
    e.last  = l;
    expected_words.push_front(e);
  endtask

  task automatic close_run();
    logic [15:0] gap;
    if (last_wr_idx == NO_WRITE) gap = run_first;
    else gap = run_first - last_wr_idx;
    if (int'(gap) >= GAP_STEP) begin
      expect_word(KIND_OFFS, GAP_VAL, 1'b0);
      expect_word(KIND_OFFS, 16'h0000, 1'b0);
      gap = gap - GAP_VAL;
    end
    expect_word(KIND_OFFS, gap, 1'b0);
    expect_word(KIND_RUN, run_len, 1'b0);
    last_wr_idx = run_first + run_len - 16'd1;
    in_run    = 1'b0;
    run_first = '0;
    run_len   = '0;
  endtask

  task automatic encode_word(input logic [15:0] w);
    int len;
    int pos;
    len = int'(scan_len_cfg);
    if (len < 1) len = 1;
    if (len > MEM_WORDS) len = MEM_WORDS;
    pos = int'(scan_pos);
    if (pos >= MEM_WORDS) pos = MEM_WORDS - 1;

    if (w != shadow_mem[pos]) begin
      expect_word(KIND_DATA, w, 1'b0);
      shadow_mem[pos] = w;
      if (!in_run) begin
        in_run    = 1'b1;
        run_first = 16'(pos);
        run_len   = 16'd1;
      end else if (run_len != LEN_SAT) begin
        run_len = run_len + 16'd1;
      end
    end else if (in_run) begin
      close_run();
    end

    if (pos + 1 >= len) begin
      if (in_run) close_run();
      expect_word(KIND_DONE, 16'h0000, 1'b1);
      in_run      = 1'b0;
      run_first   = '0;
      run_len     = '0;
      last_wr_idx = NO_WRITE;
      scan_pos    = '0;
    end else begin
      scan_pos = 16'(pos + 1);
    end
  endtask

  task automatic check_word();
    entry_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word", {out_kind, out_value, out_last}, 0);
      return;
    end
    want = expected_words.pop_back();
    if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
    if (out_value !== want.value) report_mismatch("value", out_value, want.value);
    if (out_last !== want.last) report_mismatch("last", out_last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
      scan_pos     = '0;
      run_first    = '0;
      run_len      = '0;
      last_wr_idx  = NO_WRITE;
      in_run       = 1'b0;
      scan_len_cfg = CFG_W'(MEM_WORDS);
      errors       = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (cfg_we) scan_len_cfg = cfg_scan_words;
      if (in_valid && !in_stall) encode_word(in_current_word);
    end
    pending <= expected_words.size();
  end

endmodule

[tb/sv/memory_delta_run_encoder_top_test.sv]
`timescale 1ns / 1ps

module memory_delta_run_encoder_top_test;
  import mdre_pkg::*;

  localparam int MEM_WORDS = MEM_WORDS_DEF;
  localparam int GAP_STEP  = GAP_STEP_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_ITEMS = 280;
  localparam int CFG_MAX = (1 << CFG_W) - 1;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_scan_words;
  logic             in_valid;
  logic             in_stall;
  logic [15:0]      in_current_word;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [15:0]      out_value;
  logic             out_last;

  int unsigned pending;
  int unsigned fail_count;
  int          cycle_count;

  logic [15:0] mem_image [MEM_WORDS];
  int          stim_pos;
  int          stim_len;
  int          rand_count;
  int          scan_len;
  int          cut;
  bit          calm;

  memory_delta_run_encoder_top #(
    .MEM_WORDS(MEM_WORDS),
    .GAP_STEP (GAP_STEP)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_scan_words (cfg_scan_words),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_current_word(in_current_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  memory_delta_run_encoder_checker #(
    .MEM_WORDS(MEM_WORDS),
    .GAP_STEP (GAP_STEP)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_scan_words (cfg_scan_words),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_current_word(in_current_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_last       (out_last),
    .pending        (pending),
    .errors         (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(input logic [15:0] w);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_current_word <= w;
    do @(posedge clk); while (in_stall);
    mem_image[stim_pos] = w;
    stim_pos = (stim_pos + 1 >= stim_len) ? 0 : stim_pos + 1;
  endtask

  // wait for every expected word, then for anything still in flight
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input int v);
    settle();
    cfg_we         <= 1'b1;
    cfg_scan_words <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    stim_len = (v < 1) ? 1 : ((v > MEM_WORDS) ? MEM_WORDS : v);
  endtask

  task automatic run_words(input int count, input int p_start, input int p_stop,
                           input bit noisy);
    bit          changing;
    logic [15:0] flip;
    logic [15:0] w;
    changing = 1'b0;
    repeat (count) begin
      calm = (rand_count >= 100 && rand_count < 180);
      if (noisy) begin
        w = ($urandom_range(0, 4) == 0) ? mem_image[stim_pos] : 16'($urandom);
      end else begin
        if (!changing && $urandom_range(0, 99) < p_start) changing = 1'b1;
        else if (changing && $urandom_range(0, 99) < p_stop) changing = 1'b0;
        flip = 16'($urandom);
        if (flip == 16'h0000) flip = 16'h8000;
        w = changing ? (mem_image[stim_pos] ^ flip) : mem_image[stim_pos];
      end
      send_word(w);
      rand_count++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_scan_words  = '0;
    in_valid        = 1'b0;
    in_current_word = '0;
    calm            = 1'b0;
    stim_pos        = 0;
    stim_len        = MEM_WORDS;
    rand_count      = 0;
    for (int i = 0; i < MEM_WORDS; i++) mem_image[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset length, then shrink below the current position
    send_word(16'hFFFF);
    send_word(16'h0000);
    write_cfg(0);
    send_word(16'h8001);

    // single-word scans
    send_word(16'hFFFF);
    send_word(16'h0000);
    write_cfg(1);
    send_word(16'h5555);

    // runs near the start, in the middle and reaching the scan end
    write_cfg(10);
    send_word(16'h5555);
    send_word(16'hAAAA);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h0001);
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'hFFFF);

    // full depth, shrunk mid-scan after a run has closed
    write_cfg(MEM_WORDS);
    send_word(mem_image[stim_pos] ^ 16'h00FF);
    send_word(mem_image[stim_pos] ^ 16'hFF00);
    send_word(mem_image[stim_pos]);
    write_cfg(2);
    send_word(mem_image[stim_pos] ^ 16'hFFFF);

    while (rand_count < RAND_ITEMS) begin
      scan_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                             : $urandom_range(1, 40);
      write_cfg(scan_len);
      if (scan_len > 4 && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, scan_len - 2);
        run_words(cut, $urandom_range(5, 60), $urandom_range(10, 70), 1'b0);
        write_cfg($urandom_range(0, cut));
        run_words(1, 50, 50, 1'b0);
      end else begin
        run_words(scan_len, $urandom_range(5, 60), $urandom_range(10, 70),
                  ($urandom_range(0, 5) == 0));
      end
    end

    // oversized length clamps to the full memory depth
    write_cfg(CFG_MAX);
    run_words(24, 20, 30, 1'b0);

    settle();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
